>>> design/lmbs_pkg.sv
package lmbs_pkg;

	// fixed field widths
	localparam int PLANE_W       = 2;
	localparam int ROW_W         = 4;
	localparam int BYTE_W        = 8;
	localparam int HI_BITS_W     = 2;
	localparam int COL_W         = BYTE_W + HI_BITS_W;
	localparam int TICK_W        = 9;
	localparam int CFG_IDX_W     = 2;
	localparam int BYTES_PER_ROW = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_FIELDS_W  = PLANE_W + ROW_W + 1 + BYTE_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = COL_W + 1 + 1 + ROW_W + PLANE_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// parameter defaults
	localparam int DEF_NUM_PLANES      = 3;
	localparam int DEF_NUM_MATRIX_ROWS = 16;

	// reset values and period bounds
	localparam logic [TICK_W-1:0] FIRST_PERIOD  = TICK_W'(21);
	localparam logic [TICK_W-1:0] PLANE0_RST    = TICK_W'(12);
	localparam logic [TICK_W-1:0] PLANE1_RST    = TICK_W'(20);
	localparam logic [TICK_W-1:0] PLANE2_RST    = TICK_W'(50);
	localparam logic [TICK_W-1:0] PERIOD_MAX    = TICK_W'(256);
	localparam logic [TICK_W-1:0] PERIOD_MIN    = TICK_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUN_ENABLE   = 2'd0,
		REG_PLANE0_TICKS = 2'd1,
		REG_PLANE1_TICKS = 2'd2,
		REG_PLANE2_TICKS = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	// scan event handed from the controller to the output stage
	typedef struct packed {
		logic               fire;
		logic               clocked;
		logic               marker;
		logic [ROW_W-1:0]   row;
		logic [PLANE_W-1:0] plane;
		logic               byte0_ok;
		logic               byte1_ok;
	} scan_evt_t;

	// zero counts as one tick, anything above the maximum saturates
	function automatic logic [TICK_W-1:0] clamp_period(input logic [TICK_W-1:0] v);
		logic [TICK_W-1:0] r;
		r = v;
		if (v == '0)
			r = PERIOD_MIN;
		else if (v > PERIOD_MAX)
			r = PERIOD_MAX;
		return r;
	endfunction

endpackage

>>> design/lmbs_ram.sv
module lmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> design/lmbs_scan_ctrl.sv
module lmbs_scan_ctrl
	import lmbs_pkg::*;
#(
	parameter int NUM_PLANES      = DEF_NUM_PLANES,
	parameter int NUM_MATRIX_ROWS = DEF_NUM_MATRIX_ROWS,
	parameter int DEPTH           = NUM_PLANES * NUM_MATRIX_ROWS,
	parameter int ADDR_W          = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	input  logic                 acc,
	input  logic                 opcode,
	input  logic [PLANE_W-1:0]   plane_sel,
	input  logic [ROW_W-1:0]     row_sel,
	input  logic                 byte_sel,
	output scan_evt_t            evt,
	output logic [ADDR_W-1:0]    rd_addr,
	output logic                 wr0_en,
	output logic                 wr1_en,
	output logic [ADDR_W-1:0]    wr_addr
);

	logic                  run_enable_q;
	logic [TICK_W-1:0]     plane_ticks_q [3];
	logic [TICK_W-1:0]     period_q;
	logic [PLANE_W-1:0]    plane_q;
	logic [ROW_W-1:0]      row_q;
	logic [DEPTH-1:0]      valid0_q;
	logic [DEPTH-1:0]      valid1_q;

	logic                  is_tick;
	logic                  expire;
	logic                  plane_wrap;
	logic [PLANE_W:0]      plane_inc;
	logic [ROW_W:0]        row_inc;
	logic [PLANE_W-1:0]    nxt_plane;
	logic [ROW_W-1:0]      nxt_row;
	logic                  wr_ok;

	// tick decode and next scan position
	always_comb begin
		is_tick    = acc && (opcode_t'(opcode) == OP_TICK) && run_enable_q;
		expire     = is_tick && (period_q <= PERIOD_MIN);
		plane_inc  = {1'b0, plane_q} + (PLANE_W+1)'(1);
		plane_wrap = 32'(plane_inc) >= NUM_PLANES;
		row_inc    = {1'b0, row_q} + (ROW_W+1)'(1);
		nxt_plane  = plane_wrap ? '0 : plane_inc[PLANE_W-1:0];
		nxt_row    = row_q;
		if (plane_wrap)
			nxt_row = (32'(row_inc) >= NUM_MATRIX_ROWS) ? '0 : row_inc[ROW_W-1:0];
		rd_addr = ADDR_W'(32'(nxt_plane) * NUM_MATRIX_ROWS + 32'(nxt_row));
	end

	// frame store write decode
	always_comb begin
		wr_ok   = acc && (opcode_t'(opcode) == OP_WRITE)
		          && (32'(plane_sel) < NUM_PLANES) && (32'(row_sel) < NUM_MATRIX_ROWS);
		wr_addr = ADDR_W'(32'(plane_sel) * NUM_MATRIX_ROWS + 32'(row_sel));
		wr0_en  = wr_ok && !byte_sel;
		wr1_en  = wr_ok && byte_sel;
	end

	// event for the output stage
	always_comb begin
		evt.fire     = expire;
		evt.clocked  = plane_wrap;
		evt.marker   = plane_wrap && (nxt_row == '0);
		evt.row      = nxt_row;
		evt.plane    = nxt_plane;
		evt.byte0_ok = valid0_q[rd_addr];
		evt.byte1_ok = valid1_q[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_enable_q     <= 1'b1;
			plane_ticks_q[0] <= PLANE0_RST;
			plane_ticks_q[1] <= PLANE1_RST;
			plane_ticks_q[2] <= PLANE2_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_RUN_ENABLE:   run_enable_q     <= cfg_data[0];
				REG_PLANE0_TICKS: plane_ticks_q[0] <= cfg_data;
				REG_PLANE1_TICKS: plane_ticks_q[1] <= cfg_data;
				REG_PLANE2_TICKS: plane_ticks_q[2] <= cfg_data;
				default:          run_enable_q     <= run_enable_q;
			endcase
		end
	end

	// period counter and scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= FIRST_PERIOD;
			plane_q  <= '0;
			row_q    <= '0;
		end else if (expire) begin
			plane_q  <= nxt_plane;
			row_q    <= nxt_row;
			period_q <= clamp_period(plane_ticks_q[nxt_plane]);
		end else if (is_tick) begin
			period_q <= period_q - TICK_W'(1);
		end
	end

	// written marks, an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= '0;
			valid1_q <= '0;
		end else begin
			if (wr0_en)
				valid0_q[wr_addr] <= 1'b1;
			if (wr1_en)
				valid1_q[wr_addr] <= 1'b1;
		end
	end

`ifndef SYNTH
	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		(period_q != '0) && (period_q <= PERIOD_MAX))
		else $error("period counter out of range");

	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(plane_q) < NUM_PLANES)
		else $error("plane position beyond plane count");

	a_clock_on_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		evt.fire && evt.clocked |=> (plane_q == '0) && (row_q != $past(row_q)))
		else $error("row clock without plane wrap and row step");
`endif

endmodule

>>> design/lmbs_out_stage.sv
module lmbs_out_stage
	import lmbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  scan_evt_t              evt,
	input  logic [BYTE_W-1:0]      rd0,
	input  logic [HI_BITS_W-1:0]   rd1,
	input  logic                   m_tready,
	output logic                   m_tvalid,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   s_tready
);

	logic               fire_s1;
	scan_evt_t          evt_s1;
	logic               out_v_q;
	logic [COL_W-1:0]   cols_q;
	logic               clocked_q;
	logic               marker_q;
	logic [ROW_W-1:0]   row_q;
	logic [PLANE_W-1:0] plane_q;
	logic               out_free;

	// input side stalls only when a read result cannot move on
	always_comb begin
		out_free = !out_v_q || m_tready;
		s_tready = !(fire_s1 && !out_free);
	end

	// read stage: waits on the memory data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fire_s1 <= 1'b0;
		else if (s_tready)
			fire_s1 <= evt.fire;
	end

	always_ff @(posedge clk) begin
		if (s_tready)
			evt_s1 <= evt;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_free)
			out_v_q <= fire_s1;
	end

	always_ff @(posedge clk) begin
		if (out_free && fire_s1) begin
			cols_q    <= {rd1 & {HI_BITS_W{evt_s1.byte1_ok}}, rd0 & {BYTE_W{evt_s1.byte0_ok}}};
			clocked_q <= evt_s1.clocked;
			marker_q  <= evt_s1.marker;
			row_q     <= evt_s1.row;
			plane_q   <= evt_s1.plane;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_TDATA_W'({plane_q, row_q, marker_q, clocked_q, cols_q});

`ifndef SYNTH
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && !out_free |=> fire_s1)
		else $error("pending read result dropped");

	a_move_s1: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && out_free |=> out_v_q)
		else $error("read result not loaded into output register");

	a_marker_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && marker_q |-> clocked_q && (row_q == '0))
		else $error("row marker outside row zero clock");
`endif

endmodule

>>> design/led_matrix_bitplane_scanner_core.sv
// channel  dir  signals                          content
// s        in   s_tvalid s_tready s_tdata s_tuser  tick or frame store byte write
// m        out  m_tvalid m_tready m_tdata          column bits and scan position
// cfg      in   cfg_we cfg_index cfg_data          run enable and plane periods
//
// one request per cycle while s_tready is high; a period expiry result passes the
// frame store read, then the output register, before it leaves
// reset loads counters and configuration with their reset values and clears the frame store written marks
// s_tready drops only while a result sits in the read stage and the output
// register is full and not taken
module led_matrix_bitplane_scanner_core
	import lmbs_pkg::*;
#(
	parameter int NUM_PLANES      = DEF_NUM_PLANES,
	parameter int NUM_MATRIX_ROWS = DEF_NUM_MATRIX_ROWS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// plane_sel, row_sel, byte_sel, data_byte, zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// columns, row_clock_pulse, row_marker_low, current_row, current_plane, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [TICK_W-1:0]      cfg_data
);

	localparam int DEPTH  = NUM_PLANES * NUM_MATRIX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);

	logic                 acc;
	scan_evt_t            evt;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    wr_addr;
	logic                 wr0_en;
	logic                 wr1_en;
	logic [PLANE_W-1:0]   plane_sel;
	logic [ROW_W-1:0]     row_sel;
	logic                 byte_sel;
	logic [BYTE_W-1:0]    data_byte;
	logic [BYTE_W-1:0]    rd0;
	logic [HI_BITS_W-1:0] rd1;

	// request fields
	assign acc       = s_tvalid && s_tready;
	assign plane_sel = s_tdata[PLANE_W-1:0];
	assign row_sel   = s_tdata[PLANE_W +: ROW_W];
	assign byte_sel  = s_tdata[PLANE_W+ROW_W];
	assign data_byte = s_tdata[PLANE_W+ROW_W+1 +: BYTE_W];

	lmbs_scan_ctrl #(
		.NUM_PLANES      (NUM_PLANES),
		.NUM_MATRIX_ROWS (NUM_MATRIX_ROWS),
		.DEPTH           (DEPTH),
		.ADDR_W          (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.opcode    (s_tuser),
		.plane_sel (plane_sel),
		.row_sel   (row_sel),
		.byte_sel  (byte_sel),
		.evt       (evt),
		.rd_addr   (rd_addr),
		.wr0_en    (wr0_en),
		.wr1_en    (wr1_en),
		.wr_addr   (wr_addr)
	);

	// low column byte of each plane and row
	lmbs_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store0 (
		.clk   (clk),
		.we    (wr0_en),
		.waddr (wr_addr),
		.wdata (data_byte),
		.re    (evt.fire),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	// high column bits, only the two that drive columns are kept
	lmbs_ram #(
		.WIDTH (HI_BITS_W),
		.DEPTH (DEPTH)
	) u_store1 (
		.clk   (clk),
		.we    (wr1_en),
		.waddr (wr_addr),
		.wdata (data_byte[HI_BITS_W-1:0]),
		.re    (evt.fire),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	lmbs_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.rd0      (rd0),
		.rd1      (rd1),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.s_tready (s_tready)
	);

endmodule
